/* src/qkeq_pkg.sv */
package qkeq_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [30:0] JUMP_ADD = 31'd1000000;
   localparam logic [31:0] DEBOUNCE_RESET = 32'd10000;

   typedef enum logic {
      MODE_SAMPLE = 1'b0,
      MODE_POP    = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BUTTON_ENABLE = 1'b0,
      CSR_DEBOUNCE_US   = 1'b1
   } csr_index_type;

   // pressed bit and 31-bit knob position
   typedef struct packed {
      logic        pressed;
      logic [30:0] position;
   } status_type;

   // one queue entry: status and its time stamp
   typedef struct packed {
      status_type  status;
      logic [31:0] stamp;
   } entry_type;

   // per-word outcome handed from the queue to the output stages
   typedef struct packed {
      logic      from_queue;
      logic      appended;
      logic      nonempty;
      logic      use_mem;
      entry_type newest;
   } q_result_type;

endpackage

/* src/qkeq_step.sv */
module qkeq_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   sample_accept,
   input  logic                   phase_a,
   input  logic                   phase_b,
   input  logic                   button_level,
   input  logic [31:0]            now_us,
   input  logic                   button_enable,
   input  logic [31:0]            debounce_us,
   input  qkeq_pkg::status_type   last,
   output qkeq_pkg::status_type   next
);
   import qkeq_pkg::*;

   logic [31:0] change_time_ff, change_time_in;
   logic [31:0] elapsed;
   logic        sample_ok;
   logic        level;
   logic        button_changed;
   logic [1:0]  micro;
   logic [1:0]  delta;

   always_comb begin
      // debounce: take the pin only once the hold time has run out
      elapsed   = now_us - change_time_ff;
      sample_ok = elapsed > debounce_us;
      level     = button_enable ? button_level : 1'b1;
      next.pressed   = sample_ok ? ~level : last.pressed;
      button_changed = sample_ok && (next.pressed != last.pressed);

      // phase code: AB 11=0, 10=1, 00=2, 01=3
      micro = {~phase_a, phase_a ^ phase_b};
      delta = micro - last.position[1:0];
      case (delta)
         2'd1: next.position = last.position + 31'd1;
         2'd3: next.position = last.position - 31'd1;
         2'd2: next.position = last.position + JUMP_ADD;
         default: next.position = last.position;
      endcase

      change_time_in = change_time_ff;
      if (sample_accept && button_changed) begin
         change_time_in = now_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         change_time_ff <= '0;
      end else begin
         change_time_ff <= change_time_in;
      end
   end

endmodule

/* src/qkeq_queue.sv */
module qkeq_queue #(
   parameter int QUEUE_DEPTH = qkeq_pkg::QUEUE_DEPTH_DEF,
   localparam int IW = $clog2(2 * QUEUE_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  qkeq_pkg::mode_type     mode,
   input  qkeq_pkg::status_type   next_status,
   input  logic [31:0]            now_us,
   output qkeq_pkg::status_type   newest_status,
   output qkeq_pkg::q_result_type result,
   output qkeq_pkg::entry_type    rd_data,
   output logic [IW-1:0]          unread_cnt
);
   import qkeq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam logic [IW:0]   TWO_D    = (IW+1)'(2 * QUEUE_DEPTH);
   localparam logic [IW-1:0] CNT_LAST = IW'(2 * QUEUE_DEPTH - 1);
   localparam logic [IW-1:0] FULL_LIM = IW'(QUEUE_DEPTH - 1);
   localparam logic [AW-1:0] SLOT_LAST = AW'(QUEUE_DEPTH - 1);

   // counters run modulo 2*depth, slots modulo depth alongside them
   logic [IW-1:0] wr_cnt_ff, wr_cnt_in, rd_cnt_ff, rd_cnt_in;
   logic [AW-1:0] wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic [AW-1:0] last_slot_ff, last_slot_in;
   entry_type     last_ff, last_in;
   logic          prev_pressed_ff, prev_pressed_in;

   entry_type     mem [QUEUE_DEPTH];
   entry_type     rd_data_ff;

   logic [IW:0]   diff;
   logic          is_pop, has_unread, changed, want, room;
   logic          do_write, do_append, do_pop;
   logic [AW-1:0] wr_addr;
   entry_type     new_entry;

   always_comb begin
      if (wr_cnt_ff >= rd_cnt_ff) begin
         diff = {1'b0, wr_cnt_ff} - {1'b0, rd_cnt_ff};
      end else begin
         diff = {1'b0, wr_cnt_ff} + TWO_D - {1'b0, rd_cnt_ff};
      end
      unread_cnt = diff[IW-1:0];
      has_unread = unread_cnt != '0;

      is_pop  = mode == MODE_POP;
      changed = next_status != last_ff.status;
      // if unread, append unless newest two and new status share pressed
      want    = !has_unread || (last_ff.status.pressed != next_status.pressed) ||
                (last_ff.status.pressed != prev_pressed_ff);
      room    = unread_cnt < FULL_LIM;

      do_write  = accept && !is_pop && changed;
      do_append = do_write && want && room;
      do_pop    = accept && is_pop && has_unread;

      new_entry.status = next_status;
      new_entry.stamp  = now_us;
      wr_addr = do_append ? wr_slot_ff : last_slot_ff;

      wr_cnt_in       = wr_cnt_ff;
      wr_slot_in      = wr_slot_ff;
      last_slot_in    = last_slot_ff;
      last_in         = last_ff;
      prev_pressed_in = prev_pressed_ff;
      rd_cnt_in       = rd_cnt_ff;
      rd_slot_in      = rd_slot_ff;

      if (do_write) begin
         last_in = new_entry;
      end
      if (do_append) begin
         prev_pressed_in = last_ff.status.pressed;
         last_slot_in    = wr_slot_ff;
         wr_cnt_in       = (wr_cnt_ff == CNT_LAST) ? '0 : wr_cnt_ff + IW'(1);
         wr_slot_in      = (wr_slot_ff == SLOT_LAST) ? '0 : wr_slot_ff + AW'(1);
      end
      if (do_pop) begin
         rd_cnt_in  = (rd_cnt_ff == CNT_LAST) ? '0 : rd_cnt_ff + IW'(1);
         rd_slot_in = (rd_slot_ff == SLOT_LAST) ? '0 : rd_slot_ff + AW'(1);
      end

      result.from_queue = is_pop && has_unread;
      result.use_mem    = is_pop && has_unread;
      result.appended   = !is_pop && changed && want && room;
      if (is_pop) begin
         result.nonempty = has_unread && (unread_cnt != IW'(1));
      end else begin
         result.nonempty = has_unread || (changed && want && room);
      end
      result.newest = (!is_pop && changed) ? new_entry : last_ff;
   end

   assign newest_status = last_ff.status;
   assign rd_data       = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff       <= '0;
         rd_cnt_ff       <= '0;
         wr_slot_ff      <= '0;
         rd_slot_ff      <= '0;
         last_slot_ff    <= SLOT_LAST;
         last_ff         <= '0;
         prev_pressed_ff <= 1'b0;
      end else begin
         wr_cnt_ff       <= wr_cnt_in;
         rd_cnt_ff       <= rd_cnt_in;
         wr_slot_ff      <= wr_slot_in;
         rd_slot_ff      <= rd_slot_in;
         last_slot_ff    <= last_slot_in;
         last_ff         <= last_in;
         prev_pressed_ff <= prev_pressed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_addr] <= new_entry;
      end
   end

   // a pop and a write never share a cycle, so no bypass is needed
   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_data_ff <= mem[rd_slot_ff];
      end
   end

endmodule

/* src/quadrature_knob_event_queue.sv */
// Rotary knob decoder with button debounce and a status queue.
//
// Input channel (req_*): one word per event. req_mode selects a pin
// sample (phase A/B levels, raw button level, microsecond time) or a pop
// of the oldest queued status. Every input word yields exactly one
// result word on the rsp_* channel, in order.
// Config port (csr_*): write-only, one register per csr_index, taken on
// any cycle csr_write is high; only change it while the block is idle.
//
// Path: a taken input word passes through one stage holding the queue
// outcome and memory read, then the output register, before rsp_valid
// rises; rsp_ready low can hold it in either. Throughput: one word per
// cycle, no gaps, while rsp_ready stays high; the queue memory has a
// single read / single write port.
//
// Reset: queue empty, position 0, button released, button enabled,
// debounce 10000 us. The queue memory itself is not cleared; only
// entries written since reset are ever read.
// Backpressure: with rsp_ready low up to two words sit in the pipeline;
// then req_ready drops until the receiver takes the output word.
module quadrature_knob_event_queue #(
   parameter int QUEUE_DEPTH = qkeq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic                             req_phase_a,
   input  logic                             req_phase_b,
   input  logic                             req_button_level,
   input  logic [31:0]                      req_now_us,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_pressed,
   output logic [30:0]                      rsp_position,
   output logic [31:0]                      rsp_stamp_us,
   output logic                             rsp_from_queue,
   output logic                             rsp_appended,
   output logic                             rsp_queue_nonempty,

   input  logic                             csr_write,
   input  logic [qkeq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qkeq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import qkeq_pkg::*;

   localparam int IW = $clog2(2 * QUEUE_DEPTH);

   // config registers
   logic         button_enable_ff, button_enable_in;
   logic [31:0]  debounce_us_ff, debounce_us_in;

   // handshake and stage control
   logic         req_accept;
   logic         s1_move;
   logic         s1_valid_ff, s1_valid_in;
   q_result_type s1_ff, s1_in;
   logic         rsp_valid_ff, rsp_valid_in;
   entry_type    rsp_entry_ff, rsp_entry_in;
   logic         rsp_from_queue_ff, rsp_from_queue_in;
   logic         rsp_appended_ff, rsp_appended_in;
   logic         rsp_nonempty_ff, rsp_nonempty_in;

   // datapath between the parts
   mode_type     mode;
   status_type   newest_status;
   status_type   next_status;
   q_result_type q_result;
   entry_type    rd_data;
   logic [IW-1:0] unread_cnt;

   assign mode = mode_type'(req_mode);

   // s1 drains when the output register is free or being taken
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;

   qkeq_step u_step (
      .clock         (clock),
      .reset         (reset),
      .sample_accept (req_accept && (mode == MODE_SAMPLE)),
      .phase_a       (req_phase_a),
      .phase_b       (req_phase_b),
      .button_level  (req_button_level),
      .now_us        (req_now_us),
      .button_enable (button_enable_ff),
      .debounce_us   (debounce_us_ff),
      .last          (newest_status),
      .next          (next_status)
   );

   qkeq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .mode          (mode),
      .next_status   (next_status),
      .now_us        (req_now_us),
      .newest_status (newest_status),
      .result        (q_result),
      .rd_data       (rd_data),
      .unread_cnt    (unread_cnt)
   );

   always_comb begin
      button_enable_in = button_enable_ff;
      debounce_us_in   = debounce_us_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BUTTON_ENABLE: button_enable_in = csr_wdata[0];
            CSR_DEBOUNCE_US:   debounce_us_in   = csr_wdata[31:0];
            default: ;
         endcase
      end

      // stage 1: queue outcome, memory read data lands alongside
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_in       = q_result;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      // output register: pick the popped entry or the newest one
      rsp_valid_in      = rsp_valid_ff;
      rsp_entry_in      = rsp_entry_ff;
      rsp_from_queue_in = rsp_from_queue_ff;
      rsp_appended_in   = rsp_appended_ff;
      rsp_nonempty_in   = rsp_nonempty_ff;
      if (s1_move) begin
         rsp_valid_in      = 1'b1;
         rsp_entry_in      = s1_ff.use_mem ? rd_data : s1_ff.newest;
         rsp_from_queue_in = s1_ff.from_queue;
         rsp_appended_in   = s1_ff.appended;
         rsp_nonempty_in   = s1_ff.nonempty;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_enable_ff <= 1'b1;
         debounce_us_ff   <= DEBOUNCE_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         button_enable_ff <= button_enable_in;
         debounce_us_ff   <= debounce_us_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff             <= s1_in;
      rsp_entry_ff      <= rsp_entry_in;
      rsp_from_queue_ff <= rsp_from_queue_in;
      rsp_appended_ff   <= rsp_appended_in;
      rsp_nonempty_ff   <= rsp_nonempty_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pressed        = rsp_entry_ff.status.pressed;
   assign rsp_position       = rsp_entry_ff.status.position;
   assign rsp_stamp_us       = rsp_entry_ff.stamp;
   assign rsp_from_queue     = rsp_from_queue_ff;
   assign rsp_appended       = rsp_appended_ff;
   assign rsp_queue_nonempty = rsp_nonempty_ff;

   // queue never holds more than depth-1 unread entries
   a_unread_bound: assert property (@(posedge clock) disable iff (reset)
      unread_cnt <= IW'(QUEUE_DEPTH - 1))
      else $error("unread count exceeds queue limit");

   // a word is never both a pop and an append
   a_pop_xor_append: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_from_queue && rsp_appended))
      else $error("result flags both popped and appended");

   // an append always leaves something to read
   a_append_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_appended |-> rsp_queue_nonempty)
      else $error("append reported with empty queue");

   // an empty stage 1 must never block the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input stalled with empty pipeline");

endmodule

/* sim/quadrature_knob_event_queue_check.sv */
module quadrature_knob_event_queue_check #(
   parameter int DEPTH = qkeq_pkg::QUEUE_DEPTH_DEF   // power of two
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_mode,
   input  logic                              req_phase_a,
   input  logic                              req_phase_b,
   input  logic                              req_button_level,
   input  logic [31:0]                       req_now_us,

   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_pressed,
   input  logic [30:0]                       rsp_position,
   input  logic [31:0]                       rsp_stamp_us,
   input  logic                              rsp_from_queue,
   input  logic                              rsp_appended,
   input  logic                              rsp_queue_nonempty,

   input  logic                              csr_write,
   input  logic [qkeq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qkeq_pkg::CSR_DATA_W-1:0]   csr_wdata,

   output int                                words_in_flight,
   output int                                mismatch_count
);
   import qkeq_pkg::*;

   // queue counters run modulo 2*DEPTH
   localparam int IW = $clog2(DEPTH) + 1;

   typedef struct packed {
      entry_type entry;
      logic      from_queue;
      logic      appended;
      logic      nonempty;
   } knob_report_type;

   entry_type       status_mem [DEPTH];
   logic [IW-1:0]   rd_ctr;
   logic [IW-1:0]   wr_ctr;
   logic [31:0]     last_toggle_us;
   logic            btn_wired;
   logic [31:0]     hold_us;
   knob_report_type reports_due [$];

   function automatic logic [IW-2:0] slot_of(logic [IW-1:0] ctr, int back);
      logic [IW-1:0] t;
      t = ctr - IW'(back);
      return t[IW-2:0];
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic predict_knob_word(input logic pop, input logic a, input logic b,
                                    input logic lvl, input logic [31:0] now,
                                    output knob_report_type rep);
      logic [IW-1:0] backlog;
      status_type    newest;
      status_type    older;
      status_type    next_st;
      logic [1:0]    code;
      logic [30:0]   pos;
      logic          want_new;
      backlog = wr_ctr - rd_ctr;
      rep = '0;
      if (pop) begin
         if (backlog != 0) begin
            rep.entry = status_mem[rd_ctr[IW-2:0]];
            rd_ctr = rd_ctr + IW'(1);
            rep.from_queue = 1'b1;
         end else begin
            rep.entry = status_mem[slot_of(wr_ctr, 1)];
         end
      end else begin
         newest = status_mem[slot_of(wr_ctr, 1)].status;
         older  = status_mem[slot_of(wr_ctr, 2)].status;
         next_st.pressed = newest.pressed;
         // button only looked at once the hold time has run out
         if (now - last_toggle_us > hold_us) begin
            next_st.pressed = btn_wired ? !lvl : 1'b0;
            if (next_st.pressed != newest.pressed)
               last_toggle_us = now;
         end
         code = b ? 2'd3 : 2'd2;
         if (a)
            code = code ^ 2'b11;
         pos = newest.position;
         case (2'(code - newest.position[1:0]))
            2'd1: pos = pos + 31'd1;
            2'd3: pos = pos - 31'd1;
            2'd2: pos = pos + JUMP_ADD;
            default: ;
         endcase
         next_st.position = pos;
         if (next_st != newest) begin
            want_new = backlog == 0 || next_st.pressed != newest.pressed ||
                       newest.pressed != older.pressed;
            if (want_new && backlog < DEPTH - 1) begin
               status_mem[wr_ctr[IW-2:0]] = {next_st, now};
               wr_ctr = wr_ctr + IW'(1);
               rep.appended = 1'b1;
            end else begin
               status_mem[slot_of(wr_ctr, 1)] = {next_st, now};
            end
         end
         rep.entry = status_mem[slot_of(wr_ctr, 1)];
      end
      rep.nonempty = (wr_ctr != rd_ctr);
   endtask

   always @(posedge clock) begin
      knob_report_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++)
            status_mem[i] = '0;
         rd_ctr = '0;
         wr_ctr = '0;
         last_toggle_us = '0;
         btn_wired = 1'b1;
         hold_us = DEBOUNCE_RESET;
         reports_due.delete();
         mismatch_count = 0;
      end else begin
         // output side first: a word taken at this edge cannot answer itself
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               $error("result word with no prediction waiting");
               mismatch_count++;
            end else begin
               want = reports_due.pop_front();
               check_field("pressed", want.entry.status.pressed, rsp_pressed);
               check_field("position", want.entry.status.position, rsp_position);
               check_field("stamp_us", want.entry.stamp, rsp_stamp_us);
               check_field("from_queue", want.from_queue, rsp_from_queue);
               check_field("appended", want.appended, rsp_appended);
               check_field("queue_nonempty", want.nonempty, rsp_queue_nonempty);
            end
         end
         if (csr_write) begin
            if (csr_index == CSR_BUTTON_ENABLE)
               btn_wired = csr_wdata[0];
            else if (csr_index == CSR_DEBOUNCE_US)
               hold_us = csr_wdata;
         end
         if (req_valid && req_ready) begin
            predict_knob_word(req_mode == MODE_POP, req_phase_a, req_phase_b,
                              req_button_level, req_now_us, want);
            reports_due.push_back(want);
         end
      end
      words_in_flight = reports_due.size();
   end

endmodule

/* sim/quadrature_knob_event_queue_tb.sv */
// Top of the knob decoder bench: clock, reset, stimulus on the req_ side,
// random backpressure on the rsp_ side, and the verdict. All prediction and
// comparison lives in the check module that sits beside the block.
module quadrature_knob_event_queue_tb;
   import qkeq_pkg::*;

   // bounds for the run; the slowest legal run is far below the limit
   localparam int CYCLE_LIMIT = 200000;
   // receiver hold-off: starts once this many words went in, lasts HOLD_OFF
   localparam int HOLD_AT  = 150;
   localparam int HOLD_OFF = 60;
   // window (in accepted words) with no idling on either side
   localparam int CALM_FROM = 700;
   localparam int CALM_TO   = 900;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_mode;
   logic                   req_phase_a;
   logic                   req_phase_b;
   logic                   req_button_level;
   logic [31:0]            req_now_us;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_pressed;
   logic [30:0]            rsp_position;
   logic [31:0]            rsp_stamp_us;
   logic                   rsp_from_queue;
   logic                   rsp_appended;
   logic                   rsp_queue_nonempty;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int words_in_flight;
   int mismatch_count;

   // stimulus state: knob phase code, turning direction, button pin, time
   int          words_sent = 0;
   logic [1:0]  knob_code;
   logic        turn_up;
   logic        btn_level;
   logic [31:0] now_clock;
   int          pop_pct;
   int          toggle_pct;
   int          time_span;
   int          cycles_run = 0;

   quadrature_knob_event_queue dut (.*);

   quadrature_knob_event_queue_check check_u (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hang anywhere ends the run as a failure
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // words_sent moves only at rising edges, so both sides read it safely
   // at the falling edge
   function automatic bit calm_stretch();
      return words_sent >= CALM_FROM && words_sent < CALM_TO;
   endfunction

   // Offer one word; called and returning at a falling edge. Random gaps
   // go in front of the word, valid then holds until the handshake.
   task automatic offer_word(input mode_type mode, input logic a, input logic b,
                             input logic lvl, input logic [31:0] now);
      while (!calm_stretch() && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_phase_a      <= a;
      req_phase_b      <= b;
      req_button_level <= lvl;
      req_now_us       <= now;
      do
         @(posedge clock);
      while (!req_ready);
      words_sent++;
      @(negedge clock);
   endtask

   // sample word with the pins set for a phase code (A,B: 11 10 00 01)
   task automatic turn_to(input logic [1:0] code, input logic lvl, input logic [31:0] now);
      logic [1:0] pins;
      case (code)
         2'd0: pins = 2'b11;
         2'd1: pins = 2'b10;
         2'd2: pins = 2'b00;
         default: pins = 2'b01;
      endcase
      offer_word(MODE_SAMPLE, pins[1], pins[0], lvl, now);
   endtask

   // pop word; the pin fields are don't-care, so fill them with noise
   task automatic pop_word();
      offer_word(MODE_POP, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), $urandom);
   endtask

   // sender pause: nothing goes in until every predicted word is out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (words_in_flight != 0)
         @(negedge clock);
   endtask

   task automatic set_register(input csr_index_type idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly clean rotation (runs in one direction with the odd reversal),
   // plus skipped edges, idle pins and pure noise on the phases. Pop share
   // changes every 40 words so the queue both fills up and drains.
   task automatic run_random(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            r = $urandom_range(2);
            pop_pct = (r == 0) ? 5 : (r == 1) ? 30 : 60;
         end
         if ($urandom_range(99) < pop_pct) begin
            pop_word();
         end else begin
            r = $urandom_range(99);
            if (r < 8) begin
               knob_code = 2'($urandom_range(3));
            end else if (r < 14) begin
               knob_code = knob_code + 2'd2;
            end else if (r >= 24) begin
               if ($urandom_range(99) < 12)
                  turn_up = !turn_up;
               knob_code = knob_code + (turn_up ? 2'd1 : 2'd3);
            end
            if ($urandom_range(99) < toggle_pct)
               btn_level = !btn_level;
            // rare jump anywhere on the time line, else a step forward
            if ($urandom_range(99) < 3)
               now_clock = $urandom;
            else
               now_clock = now_clock + $urandom_range(time_span);
            turn_to(knob_code, btn_level, now_clock);
         end
      end
   endtask

   // Receiver: random stalls, one long hold-off while the sender keeps
   // pushing (fills the pipe and drops req_ready), none in the calm window.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm_stretch() || $urandom_range(99) >= 31;
         end
      end
   end

   initial begin
      logic [31:0] debounce;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_SAMPLE;
      req_phase_a      = 1'b0;
      req_phase_b      = 1'b0;
      req_button_level = 1'b1;
      req_now_us       = '0;
      csr_write        = 1'b0;
      csr_index        = CSR_BUTTON_ENABLE;
      csr_wdata        = '0;
      knob_code        = 2'd0;
      turn_up          = 1'b1;
      btn_level        = 1'b1;
      now_clock        = '0;
      pop_pct          = 30;
      toggle_pct       = 20;
      time_span        = 12000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, reset settings (button wired, 10 ms hold) ----
      pop_word();                            // pop on an empty queue
      turn_to(2'd3, 1'b1, 32'd100);          // step down from 0: wraps to max
      turn_to(2'd0, 1'b1, 32'd200);          // step up: back to 0, overwrite
      turn_to(2'd0, 1'b1, 32'd300);          // nothing changed
      turn_to(2'd2, 1'b1, 32'd400);          // two-step jump
      turn_to(2'd3, 1'b1, 32'd500);
      turn_to(2'd2, 1'b1, 32'd600);
      turn_to(2'd2, 1'b0, 32'd20000);        // press, after the hold time
      turn_to(2'd1, 1'b1, 32'd20010);        // release inside hold: ignored
      turn_to(2'd1, 1'b1, 32'd30011);        // release seen
      repeat (5) pop_word();                 // drain, last one finds it empty
      turn_to(2'd1, 1'b0, 32'hffff_fff0);    // press just before time wraps
      turn_to(2'd1, 1'b1, 32'h0000_0010);    // held across the wrap
      // toggle the button until the queue is full and overwrites start
      for (int k = 0; k < 8; k++)
         turn_to(2'd1, !k[0], 32'h10 + 32'(20000 * (k + 1)));
      knob_code = 2'd1;
      btn_level = 1'b0;
      now_clock = 32'h10 + 32'(20000 * 8);

      // ---- random part over several register settings ----
      run_random(300);

      wait_idle();
      set_register(CSR_BUTTON_ENABLE, 32'd1);
      set_register(CSR_DEBOUNCE_US, 32'd0);          // no hold at all
      time_span  = 3;
      toggle_pct = 40;
      run_random(300);

      wait_idle();
      debounce = $urandom_range(500, 1);
      set_register(CSR_BUTTON_ENABLE, 32'd0);        // button not wired
      set_register(CSR_DEBOUNCE_US, debounce);
      time_span = 2 * debounce;
      run_random(250);

      wait_idle();
      set_register(CSR_BUTTON_ENABLE, 32'd1);
      set_register(CSR_DEBOUNCE_US, 32'hffff_ffff);  // button frozen
      time_span = 100000;
      run_random(150);

      wait_idle();
      debounce = $urandom_range(2000, 20);
      set_register(CSR_DEBOUNCE_US, debounce);
      time_span = 2 * debounce;
      run_random(200);

      // everything answered, then wait for any stray words
      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
